// ===== rtl/core/mips_branch_predecode_core_macros.svh =====
// Assertion macros for the MIPS branch predecode core.
`ifndef MIPS_BRANCH_PREDECODE_CORE_MACROS_SVH
`define MIPS_BRANCH_PREDECODE_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define MBPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define MBPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mbpd_pkg.sv =====
// Types, opcode constants and decode helpers for the MIPS branch predecode core.
`timescale 1ns / 1ps

package mbpd_pkg;

  // Address meaning "none"
  localparam logic [31:0] NO_ADDR      = 32'hFFFF_FFFF;

  // Magic words that end a block
  localparam logic [31:0] MAGIC_REGIMM = 32'h0407_000D;
  localparam logic [31:0] MAGIC_A      = 32'h7C1C_97C0;
  localparam logic [31:0] MAGIC_B      = 32'hF1F3_F5F7;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_COP0    = 6'd16;
  localparam logic [5:0] OP_COP1    = 6'd17;
  localparam logic [5:0] OP_BEQL    = 6'd20;
  localparam logic [5:0] OP_BNEL    = 6'd21;
  localparam logic [5:0] OP_BLEZL   = 6'd22;
  localparam logic [5:0] OP_BGTZL   = 6'd23;

  // SPECIAL function codes that change flow
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_BREAK   = 6'd13;

  // REGIMM rt codes
  localparam logic [4:0] RT_BLTZ    = 5'd0;
  localparam logic [4:0] RT_BGEZ    = 5'd1;
  localparam logic [4:0] RT_BLTZL   = 5'd2;
  localparam logic [4:0] RT_BGEZL   = 5'd3;
  localparam logic [4:0] RT_TGEI    = 5'd8;
  localparam logic [4:0] RT_TGEIU   = 5'd9;
  localparam logic [4:0] RT_TLTI    = 5'd10;
  localparam logic [4:0] RT_TLTIU   = 5'd11;
  localparam logic [4:0] RT_TEQI    = 5'd12;
  localparam logic [4:0] RT_TNEI    = 5'd14;
  localparam logic [4:0] RT_BLTZAL  = 5'd16;
  localparam logic [4:0] RT_BGEZAL  = 5'd17;

  // COP0 rs and function codes
  localparam logic [4:0] RS_MF      = 5'd0;
  localparam logic [4:0] RS_MT      = 5'd4;
  localparam int unsigned COP_CO_BIT = 4;
  localparam logic [5:0] FN_TLBR    = 6'd1;
  localparam logic [5:0] FN_TLBWI   = 6'd2;
  localparam logic [5:0] FN_TLBWR   = 6'd6;
  localparam logic [5:0] FN_TLBP    = 6'd8;
  localparam logic [5:0] FN_ERET    = 6'd24;

  // COP1 rs code for BC and its condition codes
  localparam logic [4:0] RS_BC      = 5'd8;
  localparam logic [4:0] BC_F       = 5'd0;
  localparam logic [4:0] BC_T       = 5'd1;
  localparam logic [4:0] BC_FL      = 5'd2;
  localparam logic [4:0] BC_TL      = 5'd3;

  // One bit per code: set where the instruction never changes flow
  localparam logic [63:0] SPECIAL_PLAIN_MASK = 64'hDD5F_FCFF_FFDF_00DD;
  localparam logic [63:0] OP_PLAIN_MASK      = 64'hA3A3_FFFF_0F00_FF00;
  localparam logic [31:0] COP1_PLAIN_MASK    = 32'h0033_0077;

  // Decode result
  typedef struct packed {
    logic        recognized;
    logic [31:0] target_pc;
    logic [31:0] continue_pc;
    logic        likely_branch;
    logic        has_delay_slot;
    logic        ends_block;
    logic        endless_loop;
  } dec_t;

  // Result of a supported instruction that does not change flow
  function automatic dec_t dec_plain();
    dec_t d;
    d.recognized     = 1'b1;
    d.target_pc      = NO_ADDR;
    d.continue_pc    = NO_ADDR;
    d.likely_branch  = 1'b0;
    d.has_delay_slot = 1'b0;
    d.ends_block     = 1'b0;
    d.endless_loop   = 1'b0;
    return d;
  endfunction

  // Conditional branch; a branch to pc+8 counts as no branch
  function automatic dec_t dec_cond(logic [31:0] tgt, logic [31:0] seq_pc, logic skip,
                                    logic self_loop, logic has_cont, logic quiet);
    dec_t d;
    d = dec_plain();
    if (!skip) begin
      d.target_pc      = tgt;
      d.endless_loop   = self_loop && !quiet;
      d.continue_pc    = has_cont ? seq_pc : NO_ADDR;
      d.has_delay_slot = 1'b1;
    end
    return d;
  endfunction

  // Branch-likely form; always reports its target
  function automatic dec_t dec_likely(logic [31:0] tgt, logic [31:0] seq_pc,
                                      logic self_loop, logic has_cont, logic quiet);
    dec_t d;
    d = dec_plain();
    d.target_pc      = tgt;
    d.endless_loop   = self_loop && !quiet;
    d.continue_pc    = has_cont ? seq_pc : NO_ADDR;
    d.likely_branch  = 1'b1;
    d.has_delay_slot = 1'b1;
    return d;
  endfunction

endpackage

// ===== rtl/core/mips_branch_predecode_core.sv =====
// Top level of the MIPS branch predecode core: input register, decode, result register.
`timescale 1ns / 1ps
// Classifies one MIPS instruction word at its pc for control-flow analysis.
// Input channel: in_valid/in_ready with in_pc, in_instr_word and
// in_slot_writes_compare (delay slot touches a compared register).
// Result channel: out_valid/out_ready with recognized, target and continue
// addresses (all ones when none) and the likely, delay slot, block end and
// self-loop flags.
// An accepted item passes the input register, then the result register, and
// out_valid rises once it reaches the result register.
// Throughput: one item per cycle while the receiver takes results; the decode
// between the registers is a single pass, two 32-bit adders (branch, fall-through).
// When the receiver stalls, the result register holds, the input register
// still takes one more item, and in_ready drops only when both are full.
// Reset (rst_n low, synchronous) empties both registers; no item is lost or
// made up across reset.
module mips_branch_predecode_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                in_pc,
  input  logic [31:0]                in_instr_word,
  input  logic                       in_slot_writes_compare,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_recognized,
  output logic [31:0]                out_target_pc,
  output logic [31:0]                out_continue_pc,
  output logic                       out_likely_branch,
  output logic                       out_has_delay_slot,
  output logic                       out_ends_block,
  output logic                       out_endless_loop
);
  import mbpd_pkg::*;
  `include "mips_branch_predecode_core_macros.svh"

  logic        a_valid_r, a_valid_nxt;
  logic [31:0] a_pc_r;
  logic [31:0] a_instr_r;
  logic        a_dirty_r;
  logic        out_valid_r, out_valid_nxt;
  dec_t        out_r;
  dec_t        dec;
  logic        out_load;
  logic        a_load;

  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [5:0]  fn;
  logic [15:0] imm;
  logic [31:0] rel_tgt;
  logic [31:0] seq_pc;
  logic [31:0] jmp_tgt;
  logic        skip;
  logic        self_loop;
  logic        has_regs;

  logic        unrec_data;
  logic        slotless_flag;
  logic        loop_end;

  // Handshake: result register frees when taken, input register when it moves on
  assign out_load = a_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !a_valid_r || out_load;
  assign a_load   = in_valid && in_ready;

  always_comb begin
    a_valid_nxt   = a_load || (a_valid_r && !out_load);
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
    if (a_load) begin
      a_pc_r    <= in_pc;
      a_instr_r <= in_instr_word;
      a_dirty_r <= in_slot_writes_compare;
    end
  end

  // Split the word and form the candidate addresses
  always_comb begin
    op        = a_instr_r[31:26];
    rs        = a_instr_r[25:21];
    rt        = a_instr_r[20:16];
    fn        = a_instr_r[5:0];
    imm       = a_instr_r[15:0];
    rel_tgt   = a_pc_r + {{14{imm[15]}}, imm, 2'b00} + 32'd4;
    seq_pc    = a_pc_r + 32'd8;
    jmp_tgt   = {a_pc_r[31:28], a_instr_r[25:0], 2'b00};
    // Offset of one word lands on pc+8; offset of minus one lands on pc
    skip      = (imm == 16'h0001);
    self_loop = (imm == 16'hFFFF);
    has_regs  = (rs != 5'd0) || (rt != 5'd0);
  end

  // Classify the instruction
  always_comb begin
    dec = dec_plain();
    unique case (op)
      OP_SPECIAL: begin
        priority if (SPECIAL_PLAIN_MASK[fn]) begin
          dec = dec_plain();
        end else if (fn == FN_JR || fn == FN_JALR) begin
          dec.ends_block     = 1'b1;
          dec.has_delay_slot = 1'b1;
        end else if (fn == FN_SYSCALL || fn == FN_BREAK) begin
          dec.ends_block = 1'b1;
        end else begin
          dec.recognized = 1'b0;
        end
      end
      OP_REGIMM: begin
        unique case (rt)
          RT_BLTZ, RT_BLTZAL: begin
            dec = dec_cond(rel_tgt, seq_pc, skip, self_loop, 1'b1, a_dirty_r);
          end
          RT_BGEZ, RT_BGEZAL: begin
            // With rs zero the branch is always taken; to itself it ends the block
            if (!skip) begin
              dec.has_delay_slot = 1'b1;
              dec.continue_pc    = (rs != 5'd0) ? seq_pc : NO_ADDR;
              if (self_loop && rs == 5'd0) begin
                dec.ends_block = 1'b1;
              end else begin
                dec.target_pc    = rel_tgt;
                dec.endless_loop = self_loop && !a_dirty_r;
              end
            end
          end
          RT_BLTZL, RT_BGEZL: begin
            dec = dec_likely(rel_tgt, seq_pc, self_loop, 1'b1, a_dirty_r);
          end
          RT_TGEI, RT_TGEIU, RT_TLTI, RT_TLTIU, RT_TEQI, RT_TNEI: begin
            dec = dec_plain();
          end
          default: begin
            if (a_instr_r == MAGIC_REGIMM) begin
              dec.ends_block = 1'b1;
            end else begin
              dec.recognized = 1'b0;
            end
          end
        endcase
      end
      OP_J: begin
        dec.target_pc      = jmp_tgt;
        dec.endless_loop   = (jmp_tgt == a_pc_r);
        dec.has_delay_slot = 1'b1;
      end
      OP_JAL: begin
        dec.ends_block     = 1'b1;
        dec.has_delay_slot = 1'b1;
      end
      OP_BEQ: begin
        dec = dec_cond(rel_tgt, seq_pc, skip, self_loop, has_regs, a_dirty_r);
      end
      OP_BNE, OP_BLEZ, OP_BGTZ: begin
        dec = dec_cond(rel_tgt, seq_pc, skip, self_loop, 1'b1, a_dirty_r);
      end
      OP_COP0: begin
        priority if (rs == RS_MF || rs == RS_MT) begin
          dec = dec_plain();
        end else if (rs[COP_CO_BIT] &&
                     (fn == FN_TLBR || fn == FN_TLBWI || fn == FN_TLBWR || fn == FN_TLBP)) begin
          dec = dec_plain();
        end else if (rs[COP_CO_BIT] && fn == FN_ERET) begin
          dec.ends_block = 1'b1;
        end else begin
          dec.recognized = 1'b0;
        end
      end
      OP_COP1: begin
        priority if (COP1_PLAIN_MASK[rs]) begin
          dec = dec_plain();
        end else if (rs == RS_BC) begin
          // Floating-point condition never marks a self-loop
          priority if (rt == BC_F || rt == BC_T) begin
            dec = dec_cond(rel_tgt, seq_pc, skip, self_loop, 1'b1, 1'b1);
          end else if (rt == BC_FL || rt == BC_TL) begin
            dec = dec_likely(rel_tgt, seq_pc, self_loop, 1'b1, 1'b1);
          end else begin
            dec = dec_plain();
          end
        end else begin
          dec.recognized = 1'b0;
        end
      end
      OP_BEQL: begin
        dec = dec_likely(rel_tgt, seq_pc, self_loop, has_regs, a_dirty_r);
      end
      OP_BNEL, OP_BLEZL, OP_BGTZL: begin
        dec = dec_likely(rel_tgt, seq_pc, self_loop, 1'b1, a_dirty_r);
      end
      default: begin
        priority if (OP_PLAIN_MASK[op]) begin
          dec = dec_plain();
        end else if (a_instr_r == MAGIC_A || a_instr_r == MAGIC_B) begin
          dec.ends_block = 1'b1;
        end else begin
          dec.recognized = 1'b0;
        end
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_r <= dec;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_recognized     = out_r.recognized;
  assign out_target_pc      = out_r.target_pc;
  assign out_continue_pc    = out_r.continue_pc;
  assign out_likely_branch  = out_r.likely_branch;
  assign out_has_delay_slot = out_r.has_delay_slot;
  assign out_ends_block     = out_r.ends_block;
  assign out_endless_loop   = out_r.endless_loop;

  // Flag combinations on the held result that must never occur
  assign unrec_data    = !out_r.recognized &&
                         (out_r.target_pc != NO_ADDR || out_r.continue_pc != NO_ADDR ||
                          out_r.likely_branch || out_r.has_delay_slot ||
                          out_r.ends_block || out_r.endless_loop);
  assign slotless_flag = (out_r.likely_branch || out_r.endless_loop) && !out_r.has_delay_slot;
  assign loop_end      = out_r.endless_loop && out_r.ends_block;

  // Unsupported opcodes carry no addresses and no flags
  `MBPD_ASSERT(a_unrecognized_empty, out_valid_r |-> !unrec_data, "unrecognized result has data")
  // Likely branches and self-loops always have a delay slot
  `MBPD_ASSERT(a_likely_slot, out_valid_r |-> !slotless_flag, "branch flag without delay slot")
  // A self-loop never ends the block
  `MBPD_ASSERT(a_loop_not_end, out_valid_r |-> !loop_end, "self-loop marked as block end")
  // An item leaving the input register shows up as a result next cycle
  `MBPD_ASSERT(a_advance, out_load |=> out_valid_r, "item lost between stages")
  // Both registers are empty right after reset
  `MBPD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r && !a_valid_r, "not empty after reset")

endmodule
